FILE: design/nearest_centroid_classifier_macros.svh
// assertion macros used by the checker file
`ifndef NEAREST_CENTROID_CLASSIFIER_MACROS_SVH
`define NEAREST_CENTROID_CLASSIFIER_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define NCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked assertion that also holds through reset
`define NCC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: design/ncc_pkg.sv
// shared constants, control types and helpers of the nearest-centroid classifier
package ncc_pkg;

    localparam int MAX_COMPONENTS = 16;
    localparam int MAX_CLUSTERS   = 16;
    localparam int VALUE_BITS     = 16;

    localparam int CMP_BITS  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int CLU_BITS  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int ADDR_BITS = CLU_BITS + CMP_BITS;
    localparam int SQ_BITS   = 2 * VALUE_BITS;

    // fixed field widths
    localparam int CFG_BITS      = 5;
    localparam int IDX_BITS      = 4;
    localparam int DIST_BITS     = 36;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // register indexes (byte address / 4)
    localparam logic REG_NUM_COMPONENTS = 1'b0;
    localparam logic REG_NUM_CLUSTERS   = 1'b1;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic                wr_cent;
        logic                wr_samp;
        logic                issue;
        logic [CLU_BITS-1:0] cluster;
        logic [CMP_BITS-1:0] comp;
        logic                first_comp;
        logic                last_comp;
        logic                first_clus;
        logic                last_clus;
        logic                load_out;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_status;

    // register value to a count in 1..maxv, returned minus one
    function automatic logic [CFG_BITS-1:0] clamp_last(
        input logic [CFG_BITS-1:0] v,
        input logic [CFG_BITS-1:0] maxv
    );
        logic [CFG_BITS-1:0] cnt;
        begin
            if (v == '0) begin
                cnt = CFG_BITS'(1);
            end else if (v > maxv) begin
                cnt = maxv;
            end else begin
                cnt = v;
            end
            return cnt - CFG_BITS'(1);
        end
    endfunction

endpackage

FILE: design/ncc_in_if.sv
// input word channel: load and sample items
interface ncc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [ncc_pkg::IDX_BITS-1:0]        cluster_index;
    logic [ncc_pkg::IDX_BITS-1:0]        component_index;
    logic signed [ncc_pkg::VALUE_BITS-1:0] value;
    logic                                last_component;

    modport source (
        output valid, kind, cluster_index, component_index, value, last_component,
        input  ready
    );
    modport sink (
        input  valid, kind, cluster_index, component_index, value, last_component,
        output ready
    );
endinterface

FILE: design/ncc_out_if.sv
// result word channel: nearest cluster and its squared distance
interface ncc_out_if;
    logic                          valid;
    logic                          ready;
    logic [ncc_pkg::IDX_BITS-1:0]  cluster;
    logic [ncc_pkg::DIST_BITS-1:0] distance_squared;

    modport source (
        output valid, cluster, distance_squared,
        input  ready
    );
    modport sink (
        input  valid, cluster, distance_squared,
        output ready
    );
endinterface

FILE: design/ncc_ctrl.sv
// control state machine: input handshake, search sequencing, result handoff
module ncc_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_kind,
    input  logic                           i_last,
    output logic                           o_in_ready,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    input  logic [ncc_pkg::CFG_BITS-1:0]   i_num_components,
    input  logic [ncc_pkg::CFG_BITS-1:0]   i_num_clusters,
    input  ncc_pkg::t_status               i_status,
    output ncc_pkg::t_cmd                  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_HOLD = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    logic [ncc_pkg::CLU_BITS-1:0]  r_c, n_c;
    logic [ncc_pkg::CMP_BITS-1:0]  r_p, n_p;
    logic                          r_out_valid;
    logic                          accept;
    logic                          load_out;
    logic [ncc_pkg::CMP_BITS-1:0]  comp_last;
    logic [ncc_pkg::CLU_BITS-1:0]  clus_last;
    logic                          p_end;
    logic                          c_end;

    assign comp_last = ncc_pkg::CMP_BITS'(ncc_pkg::clamp_last(i_num_components,
                           ncc_pkg::CFG_BITS'(ncc_pkg::MAX_COMPONENTS)));
    assign clus_last = ncc_pkg::CLU_BITS'(ncc_pkg::clamp_last(i_num_clusters,
                           ncc_pkg::CFG_BITS'(ncc_pkg::MAX_CLUSTERS)));

    assign p_end    = (r_p == comp_last);
    assign c_end    = (r_c == clus_last);
    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign load_out = (r_state == ST_HOLD) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        n_c     = r_c;
        n_p     = r_p;
        case (r_state)
            ST_IDLE: begin
                n_c = '0;
                n_p = '0;
                if (accept && (i_kind == ncc_pkg::KIND_SAMPLE) && i_last) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (p_end) begin
                    n_p = '0;
                    if (c_end) begin
                        n_state = ST_WAIT;
                    end else begin
                        n_c = r_c + 1'b1;
                    end
                end else begin
                    n_p = r_p + 1'b1;
                end
            end
            ST_WAIT: begin
                if (i_status.done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_c         <= '0;
            r_p         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_c     <= n_c;
            r_p     <= n_p;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.wr_cent    = accept && (i_kind == ncc_pkg::KIND_LOAD);
        o_cmd.wr_samp    = accept && (i_kind == ncc_pkg::KIND_SAMPLE);
        o_cmd.issue      = (r_state == ST_RUN);
        o_cmd.cluster    = r_c;
        o_cmd.comp       = r_p;
        o_cmd.first_comp = (r_p == '0);
        o_cmd.last_comp  = p_end;
        o_cmd.first_clus = (r_c == '0);
        o_cmd.last_clus  = c_end;
        o_cmd.load_out   = load_out;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: design/ncc_datapath.sv
// datapath: centroid memory, sample registers, distance pipeline, minimum tracking
module ncc_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ncc_pkg::t_cmd                         i_cmd,
    input  logic [ncc_pkg::IDX_BITS-1:0]          i_cluster_index,
    input  logic [ncc_pkg::IDX_BITS-1:0]          i_component_index,
    input  logic signed [ncc_pkg::VALUE_BITS-1:0] i_value,
    output ncc_pkg::t_status                      o_status,
    output logic [ncc_pkg::IDX_BITS-1:0]          o_cluster,
    output logic [ncc_pkg::DIST_BITS-1:0]         o_distance_squared
);

    localparam int DEPTH = 1 << ncc_pkg::ADDR_BITS;
    localparam int VB    = ncc_pkg::VALUE_BITS;
    localparam int DB    = ncc_pkg::DIST_BITS;

    typedef struct packed {
        logic                         valid;
        logic [ncc_pkg::CLU_BITS-1:0] cluster;
        logic                         first_comp;
        logic                         last_comp;
        logic                         first_clus;
        logic                         last_clus;
    } t_tag;

    logic [VB-1:0]                r_cent_mem [DEPTH];
    logic [VB-1:0]                r_samp [ncc_pkg::MAX_COMPONENTS];
    logic [VB-1:0]                r_cent_rd;
    logic [VB-1:0]                r_samp_rd;
    logic [VB-1:0]                r_absd;
    logic [ncc_pkg::SQ_BITS-1:0]  r_sq;
    logic [DB-1:0]                r_acc;
    logic [ncc_pkg::CLU_BITS-1:0] r_best_c;
    logic [DB-1:0]                r_best_d;
    logic                         r_done;
    logic [ncc_pkg::IDX_BITS-1:0] r_out_cluster;
    logic [DB-1:0]                r_out_dist;
    t_tag                         r_t1, r_t2, r_t3, r_t4, n_t1;

    logic                         cent_ok, samp_ok;
    logic [ncc_pkg::ADDR_BITS-1:0] wr_addr, rd_addr;
    logic signed [VB:0]           diff;
    logic [VB-1:0]                n_absd;
    logic [DB:0]                  sum_wide;
    logic [DB-1:0]                n_acc;

    assign cent_ok = (32'(i_cluster_index) < ncc_pkg::MAX_CLUSTERS)
                  && (32'(i_component_index) < ncc_pkg::MAX_COMPONENTS);
    assign samp_ok = (32'(i_component_index) < ncc_pkg::MAX_COMPONENTS);
    assign wr_addr = {ncc_pkg::CLU_BITS'(i_cluster_index),
                      ncc_pkg::CMP_BITS'(i_component_index)};
    assign rd_addr = {i_cmd.cluster, i_cmd.comp};

    // centroid memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_cent && cent_ok) begin
            r_cent_mem[wr_addr] <= i_value;
        end
        r_cent_rd <= r_cent_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_samp && samp_ok) begin
            r_samp[ncc_pkg::CMP_BITS'(i_component_index)] <= i_value;
        end
        r_samp_rd <= r_samp[i_cmd.comp];
    end

    always_comb begin
        n_t1            = '0;
        n_t1.valid      = i_cmd.issue;
        n_t1.cluster    = i_cmd.cluster;
        n_t1.first_comp = i_cmd.first_comp;
        n_t1.last_comp  = i_cmd.last_comp;
        n_t1.first_clus = i_cmd.first_clus;
        n_t1.last_clus  = i_cmd.last_clus;
    end

    assign diff   = $signed({r_samp_rd[VB-1], r_samp_rd})
                  - $signed({r_cent_rd[VB-1], r_cent_rd});
    assign n_absd = VB'(diff[VB] ? -diff : diff);

    // saturating accumulate, restarted on the first component of each cluster
    assign sum_wide = {1'b0, r_acc} + (DB + 1)'(r_sq);
    assign n_acc    = r_t3.first_comp ? DB'(r_sq)
                    : (sum_wide[DB] ? {DB{1'b1}} : sum_wide[DB-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1   <= '0;
            r_t2   <= '0;
            r_t3   <= '0;
            r_t4   <= '0;
            r_done <= 1'b0;
        end else begin
            r_t1   <= n_t1;
            r_t2   <= r_t1;
            r_t3   <= r_t2;
            r_t4   <= r_t3;
            r_done <= r_t4.valid && r_t4.last_comp && r_t4.last_clus;
        end
    end

    always_ff @(posedge i_clk) begin
        r_absd <= n_absd;
        r_sq   <= ncc_pkg::SQ_BITS'(r_absd) * ncc_pkg::SQ_BITS'(r_absd);
        if (r_t3.valid) begin
            r_acc <= n_acc;
        end
        // strict compare keeps the lower index on ties
        if (r_t4.valid && r_t4.last_comp && (r_t4.first_clus || (r_acc < r_best_d))) begin
            r_best_c <= r_t4.cluster;
            r_best_d <= r_acc;
        end
        if (i_cmd.load_out) begin
            r_out_cluster <= ncc_pkg::IDX_BITS'(r_best_c);
            r_out_dist    <= r_best_d;
        end
    end

    assign o_status.done      = r_done;
    assign o_cluster          = r_out_cluster;
    assign o_distance_squared = r_out_dist;

endmodule

FILE: design/nearest_centroid_classifier.sv
// nearest-centroid classifier top level: config registers, controller, datapath
// load items and non-last sample items are taken without leaving the idle state
// a last sample item runs the search: nc*nk component steps through the
// centroid memory read port, then pipeline drain and handoff
// no new item is taken until the result is registered; it may wait at the output
// synchronous active-low reset: counts return to 16, memories are not cleared
module nearest_centroid_classifier (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    ncc_in_if.sink                                i_in,
    ncc_out_if.source                             o_out,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ncc_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [ncc_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [ncc_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                  pready
);

    logic [ncc_pkg::CFG_BITS-1:0] r_num_components;
    logic [ncc_pkg::CFG_BITS-1:0] r_num_clusters;
    logic                         reg_wr;
    logic                         reg_sel;
    ncc_pkg::t_cmd                cmd;
    ncc_pkg::t_status             status;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_components <= ncc_pkg::CFG_BITS'(16);
            r_num_clusters   <= ncc_pkg::CFG_BITS'(16);
        end else if (reg_wr) begin
            case (reg_sel)
                ncc_pkg::REG_NUM_COMPONENTS: r_num_components <= pwdata[ncc_pkg::CFG_BITS-1:0];
                ncc_pkg::REG_NUM_CLUSTERS:   r_num_clusters   <= pwdata[ncc_pkg::CFG_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            ncc_pkg::REG_NUM_COMPONENTS:
                prdata = ncc_pkg::APB_DATA_BITS'(r_num_components);
            ncc_pkg::REG_NUM_CLUSTERS:
                prdata = ncc_pkg::APB_DATA_BITS'(r_num_clusters);
            default:
                prdata = '0;
        endcase
    end

    ncc_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in.valid),
        .i_kind           (i_in.kind),
        .i_last           (i_in.last_component),
        .o_in_ready       (i_in.ready),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .i_num_components (r_num_components),
        .i_num_clusters   (r_num_clusters),
        .i_status         (status),
        .o_cmd            (cmd)
    );

    ncc_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_cluster_index    (i_in.cluster_index),
        .i_component_index  (i_in.component_index),
        .i_value            (i_in.value),
        .o_status           (status),
        .o_cluster          (o_out.cluster),
        .o_distance_squared (o_out.distance_squared)
    );

endmodule

FILE: design/ncc_checker.sv
// port-level checks of the classifier, bound to the top level
`include "nearest_centroid_classifier_macros.svh"

module ncc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_in_kind,
    input logic                          i_in_last,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ncc_pkg::IDX_BITS-1:0]  i_out_cluster
);

    logic in_accept;
    logic search_start;

    assign in_accept    = i_in_valid && i_in_ready;
    assign search_start = in_accept && (i_in_kind == ncc_pkg::KIND_SAMPLE) && i_in_last;

    `NCC_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result word dropped")
    `NCC_ASSERT(a_out_stable, i_out_valid && !i_out_ready |=> $stable(i_out_cluster), "result changed")
    `NCC_ASSERT(a_busy_after_start, search_start |=> !i_in_ready, "input taken during search")
    `NCC_ASSERT(a_no_instant_result, $rose(i_out_valid) |-> !$past(in_accept), "result too early")
    `NCC_ASSERT_RST(a_reset_clears, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind nearest_centroid_classifier ncc_checker u_ncc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_kind     (i_in.kind),
    .i_in_last     (i_in.last_component),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_cluster (o_out.cluster)
);

FILE: bench/tb_nearest_centroid_classifier.sv
// self-checking bench for the nearest-centroid classifier against a local predictor
module tb_nearest_centroid_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                                  kind;
        logic [ncc_pkg::IDX_BITS-1:0]          cluster_index;
        logic [ncc_pkg::IDX_BITS-1:0]          component_index;
        logic signed [ncc_pkg::VALUE_BITS-1:0] value;
        logic                                  last_component;
    } t_word;

    typedef struct {
        logic [ncc_pkg::IDX_BITS-1:0]  cluster;
        logic [ncc_pkg::DIST_BITS-1:0] distance_squared;
    } t_match;

    localparam logic signed [ncc_pkg::VALUE_BITS-1:0] VALUE_MIN =
        {1'b1, {(ncc_pkg::VALUE_BITS-1){1'b0}}};
    localparam logic signed [ncc_pkg::VALUE_BITS-1:0] VALUE_MAX =
        {1'b0, {(ncc_pkg::VALUE_BITS-1){1'b1}}};
    localparam longint unsigned DIST_SAT = (64'd1 << ncc_pkg::DIST_BITS) - 64'd1;
    localparam int DRAIN_CYCLES     = 20;
    localparam int LONG_HOLD_CYCLES = 300;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [ncc_pkg::APB_ADDR_BITS-1:0] paddr;
    logic [ncc_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [ncc_pkg::APB_DATA_BITS-1:0] prdata;
    logic                              pready;

    ncc_in_if  in_ch ();
    ncc_out_if out_ch ();

    nearest_centroid_classifier u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic signed [ncc_pkg::VALUE_BITS-1:0] centroid_mem [ncc_pkg::MAX_CLUSTERS]
                                                        [ncc_pkg::MAX_COMPONENTS];
    logic signed [ncc_pkg::VALUE_BITS-1:0] sample_vec [ncc_pkg::MAX_COMPONENTS];
    logic [ncc_pkg::CFG_BITS-1:0] cfg_components = ncc_pkg::CFG_BITS'(ncc_pkg::MAX_COMPONENTS);
    logic [ncc_pkg::CFG_BITS-1:0] cfg_clusters   = ncc_pkg::CFG_BITS'(ncc_pkg::MAX_CLUSTERS);

    t_word  pending_words [$];
    t_match expected_matches [$];

    // stimulus bookkeeping: which store entries hold a written value
    bit cent_seen [ncc_pkg::MAX_CLUSTERS][ncc_pkg::MAX_COMPONENTS];
    bit samp_seen [ncc_pkg::MAX_COMPONENTS];
    int plan_components = ncc_pkg::MAX_COMPONENTS;
    int plan_clusters   = ncc_pkg::MAX_CLUSTERS;
    int words_made;

    int     send_idle_pct;
    int     stall_pct;
    bit     hold_request;
    int     hold_left;
    logic   in_fire;
    t_word  next_word;
    t_match head;
    int     failures;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int count_of(input logic [ncc_pkg::CFG_BITS-1:0] raw,
                                    input int limit);
        if (raw == '0) return 1;
        if (int'(raw) > limit) return limit;
        return int'(raw);
    endfunction

    function automatic void classify_word(input t_word w);
        int              nc;
        int              nk;
        int              best;
        longint          diff;
        longint unsigned sq;
        longint unsigned sum;
        longint unsigned best_sum;
        if (w.kind == ncc_pkg::KIND_LOAD) begin
            centroid_mem[w.cluster_index][w.component_index] = w.value;
        end else begin
            // the last component is stored before the search starts
            sample_vec[w.component_index] = w.value;
            if (w.last_component) begin
                nc = count_of(cfg_components, ncc_pkg::MAX_COMPONENTS);
                nk = count_of(cfg_clusters, ncc_pkg::MAX_CLUSTERS);
                best = 0;
                best_sum = 0;
                for (int c = 0; c < nk; c++) begin
                    sum = 0;
                    for (int p = 0; p < nc; p++) begin
                        diff = longint'(sample_vec[p]) - longint'(centroid_mem[c][p]);
                        sq = diff * diff;
                        sum = (sq > DIST_SAT - sum) ? DIST_SAT : sum + sq;
                    end
                    // strict compare keeps the lower index on ties
                    if (c == 0 || sum < best_sum) begin
                        best = c;
                        best_sum = sum;
                    end
                end
                expected_matches.push_back('{cluster: ncc_pkg::IDX_BITS'(best),
                                             distance_squared:
                                                 ncc_pkg::DIST_BITS'(best_sum)});
            end
        end
    endfunction

    function automatic logic signed [ncc_pkg::VALUE_BITS-1:0] pick_value();
        int near_zero;
        near_zero = int'($urandom_range(8)) - 4;
        case ($urandom_range(7))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2, 3: return ncc_pkg::VALUE_BITS'(near_zero);
            default: return ncc_pkg::VALUE_BITS'($urandom);
        endcase
    endfunction

    function automatic void queue_word(input logic kind, input int ci, input int pi,
                                       input logic signed [ncc_pkg::VALUE_BITS-1:0] val,
                                       input logic last);
        t_word w;
        w.kind = kind;
        w.cluster_index = ncc_pkg::IDX_BITS'(ci);
        w.component_index = ncc_pkg::IDX_BITS'(pi);
        w.value = val;
        w.last_component = last;
        pending_words.push_back(w);
        if (kind == ncc_pkg::KIND_LOAD) cent_seen[ci][pi] = 1'b1;
        else samp_seen[pi] = 1'b1;
        words_made++;
    endfunction

    // a search word, preceded by writes of any entry the search would read unwritten
    function automatic void queue_search(input int ci, input int pi,
                                         input logic signed [ncc_pkg::VALUE_BITS-1:0] val);
        for (int c = 0; c < plan_clusters; c++) begin
            for (int p = 0; p < plan_components; p++) begin
                if (!cent_seen[c][p])
                    queue_word(ncc_pkg::KIND_LOAD, c, p, pick_value(), 1'b0);
            end
        end
        for (int p = 0; p < plan_components; p++) begin
            if (p != pi && !samp_seen[p])
                queue_word(ncc_pkg::KIND_SAMPLE, $urandom_range(15), p, pick_value(), 1'b0);
        end
        queue_word(ncc_pkg::KIND_SAMPLE, ci, pi, val, 1'b1);
    endfunction

    function automatic void gen_items(input int count);
        int   stop_at;
        int   first_p;
        int   ci;
        int   pi;
        logic kind;
        logic last;
        stop_at = words_made + count;
        while (words_made < stop_at) begin
            if ($urandom_range(99) < 75) begin
                // refresh a few centroids, then a full vector in rotated order
                repeat ($urandom_range(3))
                    queue_word(ncc_pkg::KIND_LOAD, $urandom_range(plan_clusters - 1),
                               $urandom_range(plan_components - 1), pick_value(),
                               1'($urandom_range(1)));
                first_p = $urandom_range(plan_components - 1);
                for (int i = 0; i < plan_components - 1; i++)
                    queue_word(ncc_pkg::KIND_SAMPLE, $urandom_range(15),
                               (first_p + i) % plan_components, pick_value(), 1'b0);
                queue_search($urandom_range(15),
                             (first_p + plan_components - 1) % plan_components, pick_value());
            end else begin
                kind = 1'($urandom_range(1));
                last = 1'($urandom_range(1));
                ci = $urandom_range(15);
                pi = $urandom_range(15);
                if (kind == ncc_pkg::KIND_SAMPLE && last) queue_search(ci, pi, pick_value());
                else queue_word(kind, ci, pi, pick_value(), last);
            end
        end
    endfunction

    task automatic write_reg(input logic idx, input logic [ncc_pkg::CFG_BITS-1:0] field);
        logic [ncc_pkg::APB_DATA_BITS-1:0] data;
        data = $urandom;
        data[ncc_pkg::CFG_BITS-1:0] = field;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ncc_pkg::APB_ADDR_BITS'(int'(idx) * 4);
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || in_ch.valid || expected_matches.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_sizes(input logic [ncc_pkg::CFG_BITS-1:0] raw_nc,
                             input logic [ncc_pkg::CFG_BITS-1:0] raw_nk,
                             input int send_pct, input int recv_pct);
        drain();
        // a load word may still be in flight after the last result
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(ncc_pkg::REG_NUM_COMPONENTS, raw_nc);
        write_reg(ncc_pkg::REG_NUM_CLUSTERS, raw_nk);
        plan_components = count_of(raw_nc, ncc_pkg::MAX_COMPONENTS);
        plan_clusters   = count_of(raw_nk, ncc_pkg::MAX_CLUSTERS);
        send_idle_pct   = send_pct;
        stall_pct       = recv_pct;
    endtask

    // word driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_word = pending_words.pop_front();
                in_ch.kind            <= next_word.kind;
                in_ch.cluster_index   <= next_word.cluster_index;
                in_ch.component_index <= next_word.component_index;
                in_ch.value           <= next_word.value;
                in_ch.last_component  <= next_word.last_component;
                in_ch.valid           <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and an occasional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request) begin
            out_ch.ready <= 1'b0;
            hold_left <= LONG_HOLD_CYCLES;
            hold_request <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // predictor and checker, sampled at the rising edge
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                case (paddr >> 2)
                    ncc_pkg::REG_NUM_COMPONENTS: cfg_components = pwdata[ncc_pkg::CFG_BITS-1:0];
                    ncc_pkg::REG_NUM_CLUSTERS:   cfg_clusters   = pwdata[ncc_pkg::CFG_BITS-1:0];
                    default: ;
                endcase
            end
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (expected_matches.size() == 0) begin
                    $error("unexpected result word: cluster %0d distance_squared %0d",
                           out_ch.cluster, out_ch.distance_squared);
                    failures++;
                end else begin
                    head = expected_matches.pop_front();
                    if (out_ch.cluster !== head.cluster) begin
                        $error("cluster: expected %0d, actual %0d", head.cluster,
                               out_ch.cluster);
                        failures++;
                    end
                    if (out_ch.distance_squared !== head.distance_squared) begin
                        $error("distance_squared: expected %0d, actual %0d",
                               head.distance_squared, out_ch.distance_squared);
                        failures++;
                    end
                end
            end
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                classify_word('{in_ch.kind, in_ch.cluster_index, in_ch.component_index,
                                in_ch.value, in_ch.last_component});
        end
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = ncc_pkg::KIND_LOAD;
        in_ch.cluster_index = '0;
        in_ch.component_index = '0;
        in_ch.value = '0;
        in_ch.last_component = 1'b0;
        out_ch.ready = 1'b0;
        in_fire = 1'b0;
        hold_request = 1'b0;
        hold_left = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        failures = 0;
        words_made = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, ties, last mark on a load, top indices
        set_sizes(5'd2, 5'd3, 0, 0);
        queue_word(ncc_pkg::KIND_LOAD, 0, 0, VALUE_MAX, 1'b0);
        queue_word(ncc_pkg::KIND_LOAD, 0, 1, VALUE_MIN, 1'b1);
        queue_word(ncc_pkg::KIND_LOAD, 1, 0, 16'sd100, 1'b0);
        queue_word(ncc_pkg::KIND_LOAD, 1, 1, -16'sd100, 1'b0);
        queue_word(ncc_pkg::KIND_LOAD, 2, 0, 16'sd100, 1'b0);
        queue_word(ncc_pkg::KIND_LOAD, 2, 1, -16'sd100, 1'b0);
        queue_word(ncc_pkg::KIND_LOAD, 15, 15, -16'sd1, 1'b1);
        queue_word(ncc_pkg::KIND_SAMPLE, 0, 15, VALUE_MIN, 1'b0);
        queue_word(ncc_pkg::KIND_SAMPLE, 7, 0, 16'sd100, 1'b0);
        queue_word(ncc_pkg::KIND_SAMPLE, 0, 1, -16'sd100, 1'b1);
        queue_word(ncc_pkg::KIND_SAMPLE, 0, 0, VALUE_MIN, 1'b0);
        queue_word(ncc_pkg::KIND_SAMPLE, 15, 1, VALUE_MAX, 1'b1);
        // all three centroids at the same far corner: widest distance, tie to cluster 0
        queue_word(ncc_pkg::KIND_LOAD, 1, 0, VALUE_MAX, 1'b0);
        queue_word(ncc_pkg::KIND_LOAD, 1, 1, VALUE_MIN, 1'b0);
        queue_word(ncc_pkg::KIND_LOAD, 2, 0, VALUE_MAX, 1'b0);
        queue_word(ncc_pkg::KIND_LOAD, 2, 1, VALUE_MIN, 1'b0);
        queue_word(ncc_pkg::KIND_SAMPLE, 3, 0, VALUE_MIN, 1'b0);
        queue_word(ncc_pkg::KIND_SAMPLE, 15, 1, VALUE_MAX, 1'b1);
        queue_word(ncc_pkg::KIND_SAMPLE, 0, 1, 16'sd0, 1'b1);

        set_sizes(5'd4, 5'd5, 0, 0);
        gen_items(300);

        // zero counts as one
        set_sizes(5'd0, 5'd0, 75, 0);
        gen_items(150);

        // out-of-range value saturates to the maximum
        set_sizes(5'd31, 5'd2, 0, 75);
        gen_items(250);

        // long receiver hold-off while words keep coming
        set_sizes(5'd3, 5'd31, 28, 28);
        gen_items(250);
        hold_request = 1'b1;

        // full size, with a pause until every result is back
        set_sizes(5'd16, 5'd16, 0, 0);
        gen_items(80);
        drain();
        gen_items(80);

        set_sizes(5'd17, 5'd1, 0, 75);
        gen_items(200);

        set_sizes(5'd6, 5'd7, 75, 0);
        gen_items(250);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // well beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
